>>> src/lsh_pkg.sv
`timescale 1ns / 1ps

package lsh_pkg;

  // line buffer depth, the widest frame the block takes
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WEFF_W    = COL_W + 1;

  // fixed field widths
  localparam int DIM_W     = 11;
  localparam int PIX_W     = 8;
  localparam int RGB_W     = 3 * PIX_W;
  localparam int CFG_IDX_W = 2;

  typedef logic [RGB_W-1:0] rgb_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

>>> src/lsh_pix_in_if.sv
`timescale 1ns / 1ps

interface lsh_pix_in_if;
  import lsh_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_red;
  logic [PIX_W-1:0] pix_green;
  logic [PIX_W-1:0] pix_blue;
  logic             drain;

  modport source (output valid, output pix_red, output pix_green, output pix_blue,
                  output drain, input ready);
  modport sink   (input valid, input pix_red, input pix_green, input pix_blue,
                  input drain, output ready);
endinterface

>>> src/lsh_pix_out_if.sv
`timescale 1ns / 1ps

interface lsh_pix_out_if;
  import lsh_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

>>> src/laplacian_sharpen_3x3_rgb_core.sv
`timescale 1ns / 1ps

// 3x3 cross sharpening of an rgb pixel stream in raster order: each interior pixel becomes
// 5*centre minus its up, down, left and right neighbours per channel, clamped to 0..255;
// pixels on the first or last row or column pass through. the block takes one item per
// clock and keeps that rate as long as the result side takes results; the two line buffers
// are read when an item is accepted and written from the work stage, with a bypass between
// neighbouring items. the result for frame position k leaves with the item at position
// k+frame_width+1, so after the last pixel frame_width+1 drain items flush the frame;
// frame_end marks the last pixel. a drain before any item of a frame is taken and dropped.
// the work stage and result are registered. a configuration write restarts the frame
// (line buffers keep their contents); write only while the block is idle.
module laplacian_sharpen_3x3_rgb_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsh_pkg::DIM_W-1:0]     cfg_wdata,
  lsh_pix_in_if.sink                    in_pix,
  lsh_pix_out_if.source                 out_pix
);
  import lsh_pkg::*;

  // per channel sharpen with clamp, done on unsigned sums
  function automatic logic [PIX_W-1:0] sharpen(input logic [PIX_W-1:0] c,
                                               input logic [PIX_W-1:0] u,
                                               input logic [PIX_W-1:0] d,
                                               input logic [PIX_W-1:0] l,
                                               input logic [PIX_W-1:0] r);
    logic [PIX_W+2:0] pos;
    logic [PIX_W+1:0] neg;
    logic [PIX_W+2:0] diff;
    logic [PIX_W-1:0] res;
    pos = ({3'b000, c} << 2) + {3'b000, c};
    neg = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
    diff = pos - {1'b0, neg};
    if ({1'b0, neg} >= pos) begin
      res = '0;
    end else if (diff > (PIX_W+3)'((1 << PIX_W) - 1)) begin
      res = '1;
    end else begin
      res = diff[PIX_W-1:0];
    end
    return res;
  endfunction

  // configuration
  logic [DIM_W-1:0]  frame_width_r, frame_height_r;
  logic [WEFF_W-1:0] w_eff, w_plus1;
  logic [DIM_W-1:0]  h_eff;
  logic [COL_W-1:0]  last_col;

  // input side position counters
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [WEFF_W-1:0] fill_r, fill_nxt;      // frame position, held at width+1
  logic [COL_W-1:0]  ocol_r, ocol_nxt;      // position of the next result
  logic [DIM_W-1:0]  orow_r, orow_nxt;

  // work stage
  logic              s1_valid_r;
  logic              s1_emit_r, s1_inter_r, s1_end_r, s1_col0_r;
  logic [COL_W-1:0]  s1_col_r;
  rgb_t              s1_px_r;
  logic              s1_go;

  // line buffers, read data and write bypass
  rgb_t              line_a [MAX_WIDTH];    // one row back
  rgb_t              line_b [MAX_WIDTH];    // two rows back
  rgb_t              rd_a_r, rd_b_r, rd_w_r;
  logic              fwd_col_r, fwd_w_r;
  rgb_t              byp_a_r, byp_b_r;
  rgb_t              eff_top, eff_mid, eff_wrap;

  // cross window
  rgb_t              win_t2_r, win_m1_r, win_m2_r, win_b2_r;

  // result register
  logic              out_valid_r, out_end_r;
  rgb_t              out_rgb_r, res_rgb;

  logic              in_fire, idle_drain, take, emit, interior, last_pix;
  rgb_t              in_px;

  // effective frame size: width 0 acts as 1, beyond the buffer as its depth; height 0 as 1
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if ((DIM_W+WEFF_W)'(frame_width_r) > (DIM_W+WEFF_W)'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width_r);
    end
    h_eff = (frame_height_r == '0) ? DIM_W'(1) : frame_height_r;
  end

  assign w_plus1  = w_eff + WEFF_W'(1);
  assign last_col = COL_W'(w_eff - WEFF_W'(1));

  // accept side: all position bookkeeping is settled here
  assign in_pix.ready = !s1_valid_r || s1_go;
  assign in_fire      = in_pix.valid && in_pix.ready;
  assign idle_drain   = in_pix.drain && (fill_r == '0);
  assign take         = in_fire && !idle_drain;
  assign emit         = (fill_r == w_plus1);
  assign in_px        = in_pix.drain ? '0 : {in_pix.pix_red, in_pix.pix_green, in_pix.pix_blue};

  // interior test for the next result, border pixels pass through
  assign interior = (ocol_r != '0) && ((WEFF_W'(ocol_r) + WEFF_W'(2)) <= w_eff) &&
                    (orow_r != '0) && ((DIM_W+1)'(orow_r) + (DIM_W+1)'(2) <= (DIM_W+1)'(h_eff));
  assign last_pix = (ocol_r == last_col) && (orow_r == h_eff - DIM_W'(1));

  always_comb begin
    col_nxt  = (WEFF_W'(col_r) + WEFF_W'(1) == w_eff) ? '0 : col_r + COL_W'(1);
    fill_nxt = emit ? fill_r : fill_r + WEFF_W'(1);
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (emit) begin
      if (last_pix) begin
        // frame complete: everything back to the start of a frame
        col_nxt  = '0;
        fill_nxt = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end else if (ocol_r == last_col) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + DIM_W'(1);
      end else begin
        ocol_nxt = ocol_r + COL_W'(1);
      end
    end
  end

  // work stage leaves when it has no result or the result register is free
  assign s1_go = s1_valid_r && (!s1_emit_r || !out_valid_r || out_pix.ready);

  // buffer reads with the write of the item ahead folded in
  assign eff_mid  = fwd_col_r ? byp_a_r : rd_a_r;
  assign eff_top  = fwd_col_r ? byp_b_r : rd_b_r;
  assign eff_wrap = fwd_w_r   ? byp_b_r : rd_w_r;

  // kernel over the window before this item's shift, plus its line_a read on the right
  always_comb begin
    res_rgb = '0;
    if (s1_inter_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        res_rgb[ch*PIX_W +: PIX_W] = sharpen(win_m2_r[ch*PIX_W +: PIX_W],
                                             win_t2_r[ch*PIX_W +: PIX_W],
                                             win_b2_r[ch*PIX_W +: PIX_W],
                                             win_m1_r[ch*PIX_W +: PIX_W],
                                             eff_mid[ch*PIX_W +: PIX_W]);
      end
    end else begin
      // border: the centre, or at column zero the last entry two rows back
      res_rgb = s1_col0_r ? eff_wrap : win_m2_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(640);
      frame_height_r <= DIM_W'(480);
      col_r          <= '0;
      fill_r         <= '0;
      ocol_r         <= '0;
      orow_r         <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      win_t2_r       <= '0;
      win_m1_r       <= '0;
      win_m2_r       <= '0;
      win_b2_r       <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          frame_width_r <= cfg_wdata;
        end else begin
          frame_height_r <= cfg_wdata;
        end
        // restart the frame
        col_r    <= '0;
        fill_r   <= '0;
        ocol_r   <= '0;
        orow_r   <= '0;
        win_t2_r <= '0;
        win_m1_r <= '0;
        win_m2_r <= '0;
        win_b2_r <= '0;
      end else begin
        if (take) begin
          col_r  <= col_nxt;
          fill_r <= fill_nxt;
          ocol_r <= ocol_nxt;
          orow_r <= orow_nxt;
        end
        if (s1_go) begin
          win_t2_r <= eff_top;
          win_m1_r <= win_m2_r;
          win_m2_r <= eff_mid;
          win_b2_r <= s1_px_r;
        end
      end

      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_go && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_pix.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // work stage payload and buffer reads, captured at accept
  always_ff @(posedge clk) begin
    if (take) begin
      s1_emit_r  <= emit;
      s1_inter_r <= interior;
      s1_end_r   <= last_pix;
      s1_col0_r  <= (col_r == '0);
      s1_col_r   <= col_r;
      s1_px_r    <= in_px;
      rd_a_r     <= line_a[col_r];
      rd_b_r     <= line_b[col_r];
      rd_w_r     <= line_b[last_col];
      // the item ahead writes this same edge, so take its data instead
      fwd_col_r  <= s1_go && (s1_col_r == col_r);
      fwd_w_r    <= s1_go && (s1_col_r == last_col);
      byp_a_r    <= s1_px_r;
      byp_b_r    <= eff_mid;
    end
  end

  // line buffer writes: the new pixel moves in, the old row moves down
  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_a[s1_col_r] <= s1_px_r;
      line_b[s1_col_r] <= eff_mid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_rgb_r <= res_rgb;
      out_end_r <= s1_end_r;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.out_red   = out_rgb_r[2*PIX_W +: PIX_W];
  assign out_pix.out_green = out_rgb_r[PIX_W +: PIX_W];
  assign out_pix.out_blue  = out_rgb_r[0 +: PIX_W];
  assign out_pix.frame_end = out_end_r;

endmodule
